// File: src/bnha_pkg.sv
// types and constants shared by the blocked two-axis histogram
package bnha_pkg;

    // widths of the fixed item and register fields
    localparam int ActionW   = 2;
    localparam int CoordW    = 16;
    localparam int WeightW   = 16;
    localparam int ScaleW    = 16;
    localparam int BinsW     = 7;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;
    localparam int AddrOutW  = 12;
    localparam int ValueW    = 32;
    localparam int OvfW      = 40;
    localparam int ScaleFrac = 8;

    typedef logic [ActionW-1:0]  t_action;
    typedef logic [CfgIdxW-1:0]  t_cfg_idx;
    typedef logic [CfgDataW-1:0] t_cfg_data;

    localparam t_action ACT_ACCUM = 2'd0;
    localparam t_action ACT_QUERY = 2'd1;
    localparam t_action ACT_CLEAR = 2'd2;

    localparam t_cfg_idx CFG_AXIS0_LOW   = 3'd0;
    localparam t_cfg_idx CFG_AXIS1_LOW   = 3'd1;
    localparam t_cfg_idx CFG_AXIS0_SCALE = 3'd2;
    localparam t_cfg_idx CFG_AXIS1_SCALE = 3'd3;
    localparam t_cfg_idx CFG_AXIS0_BINS  = 3'd4;
    localparam t_cfg_idx CFG_AXIS1_BINS  = 3'd5;

endpackage

// File: src/blocked_nd_histogram_accumulator.sv
// blocked two-axis weighted histogram with a single-port cell memory
//
//  channel   ports                                         handshake
//  item in   i_action i_coord_0 i_coord_1 i_sample_weight  start, busy
//  result    o_in_range o_cell_address o_value             o_valid (one cycle)
//            o_overflow_total
//  config    i_cfg_idx i_cfg_wdata                          i_cfg_we
//
//  accumulate and query run these steps from accept to the o_valid cycle: multiply,
//  bin and range, block address, memory read, saturate and write back; the next
//  word is taken in the o_valid cycle, so a new word waits until the last is done
//  clear sweeps the cell memory one entry a cycle, then gives the result word
//  after reset the same sweep runs with busy high and no result word
//  the receiver cannot stall; a result is shown for exactly one cycle
module blocked_nd_histogram_accumulator #(
    parameter int MAX_BINS   = 64,
    parameter int LOG2_BLOCK = 2,
    parameter int CELL_BITS  = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  bnha_pkg::t_action                      i_action,
    input  logic signed [bnha_pkg::CoordW-1:0]     i_coord_0,
    input  logic signed [bnha_pkg::CoordW-1:0]     i_coord_1,
    input  logic signed [bnha_pkg::WeightW-1:0]    i_sample_weight,
    input  logic                                   i_cfg_we,
    input  bnha_pkg::t_cfg_idx                     i_cfg_idx,
    input  bnha_pkg::t_cfg_data                    i_cfg_wdata,
    output logic                                   o_valid,
    output logic                                   o_in_range,
    output logic [bnha_pkg::AddrOutW-1:0]          o_cell_address,
    output logic signed [bnha_pkg::ValueW-1:0]     o_value,
    output logic signed [bnha_pkg::OvfW-1:0]       o_overflow_total
);
    import bnha_pkg::*;

    localparam int BlkMask  = (1 << LOG2_BLOCK) - 1;
    localparam int MaxCols  = (MAX_BINS + BlkMask) >> LOG2_BLOCK;
    localparam int Depth    = (MaxCols * MaxCols) << (2 * LOG2_BLOCK);
    localparam int AW       = $clog2(Depth);
    localparam int BW       = $clog2(MAX_BINS + 1);
    localparam int CBW      = (BW > BinsW) ? BW : BinsW;
    localparam int IW       = $clog2(MAX_BINS);
    localparam int XW       = IW + LOG2_BLOCK;
    localparam int CW       = $clog2(MaxCols + 1);
    localparam int PW       = CoordW + 1 + ScaleW + 1;
    localparam int QW       = PW - ScaleFrac;
    localparam int VW       = ((CELL_BITS > ValueW) ? CELL_BITS : ValueW) + 1;
    localparam int OVW      = ((OvfW > ValueW) ? OvfW : ValueW) + 1;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_BIN,
        S_ADDR,
        S_RD,
        S_UPD
    } t_state;

    // configuration
    logic signed [CoordW-1:0] r_low0, r_low1;
    logic [ScaleW-1:0]        r_scl0, r_scl1;
    logic [BinsW-1:0]         r_bins0, r_bins1;

    // control
    t_state                   r_state;
    logic [AW-1:0]            r_clr_addr;
    logic                     r_clr_reply;
    logic signed [OvfW-1:0]   r_ovf;
    logic                     r_valid;
    logic                     r_in_range_o;
    logic [AddrOutW-1:0]      r_cell_addr_o;
    logic signed [ValueW-1:0] r_value_o;

    // datapath
    logic                      r_accum;
    logic signed [WeightW-1:0] r_weight;
    logic signed [PW-1:0]      r_p0, r_p1;
    logic [XW-1:0]             r_i0, r_i1;
    logic                      r_inr;
    logic [AW-1:0]             r_addr;
    logic signed [CELL_BITS-1:0] r_rdata;

    logic signed [CELL_BITS-1:0] mem [Depth];

    logic                      w_accept;
    logic signed [CoordW:0]    w_diff0, w_diff1;
    logic signed [ScaleW:0]    w_sc0, w_sc1;
    logic signed [QW-1:0]      w_b0, w_b1;
    logic [CBW-1:0]            w_clamp0, w_clamp1;
    logic [CW-1:0]             w_cols;
    logic                      w_inr0, w_inr1;
    logic [AW-1:0]             w_addr;
    logic signed [CELL_BITS:0] w_csum;
    logic signed [CELL_BITS-1:0] w_new_cell;
    logic signed [OvfW:0]      w_osum;
    logic signed [OvfW-1:0]    w_new_ovf;
    logic signed [ValueW-1:0]  w_value;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic signed [CELL_BITS-1:0] w_wdata;
    logic [AW+AddrOutW-1:0]    w_addr_ext;

    function automatic logic [CBW-1:0] clamp_bins(input logic [BinsW-1:0] b);
        logic [CBW-1:0] bx;
        bx = CBW'(b);
        if (bx > CBW'(MAX_BINS)) begin
            return CBW'(MAX_BINS);
        end
        return bx;
    endfunction

    // product in Q.8, truncated toward zero
    function automatic logic signed [QW-1:0] trunc_bin(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'({ScaleFrac{p[PW-1]}});
        return t[PW-1:ScaleFrac];
    endfunction

    function automatic logic signed [ValueW-1:0] sat_cell32(
        input logic signed [CELL_BITS-1:0] v
    );
        logic signed [VW-1:0] x;
        x = VW'(v);
        if (x > $signed(VW'({1'b0, {(ValueW-1){1'b1}}}))) begin
            return {1'b0, {(ValueW-1){1'b1}}};
        end
        if (x < $signed({{(VW-ValueW+1){1'b1}}, {(ValueW-1){1'b0}}})) begin
            return {1'b1, {(ValueW-1){1'b0}}};
        end
        return x[ValueW-1:0];
    endfunction

    function automatic logic signed [ValueW-1:0] sat_ovf32(input logic signed [OvfW-1:0] v);
        logic signed [OVW-1:0] x;
        x = OVW'(v);
        if (x > $signed(OVW'({1'b0, {(ValueW-1){1'b1}}}))) begin
            return {1'b0, {(ValueW-1){1'b1}}};
        end
        if (x < $signed({{(OVW-ValueW+1){1'b1}}, {(ValueW-1){1'b0}}})) begin
            return {1'b1, {(ValueW-1){1'b0}}};
        end
        return x[ValueW-1:0];
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_diff0 = {i_coord_0[CoordW-1], i_coord_0} - {r_low0[CoordW-1], r_low0};
    assign w_diff1 = {i_coord_1[CoordW-1], i_coord_1} - {r_low1[CoordW-1], r_low1};
    assign w_sc0   = {1'b0, r_scl0};
    assign w_sc1   = {1'b0, r_scl1};

    assign w_b0     = trunc_bin(r_p0);
    assign w_b1     = trunc_bin(r_p1);
    assign w_clamp0 = clamp_bins(r_bins0);
    assign w_clamp1 = clamp_bins(r_bins1);
    assign w_inr0   = !w_b0[QW-1] && (w_b0[QW-2:0] < (QW-1)'(w_clamp0));
    assign w_inr1   = !w_b1[QW-1] && (w_b1[QW-2:0] < (QW-1)'(w_clamp1));

    // block columns follow the bins in use on axis 1
    assign w_cols = CW'((CBW+LOG2_BLOCK+1)'(w_clamp1) + (CBW+LOG2_BLOCK+1)'(BlkMask)
                        >> LOG2_BLOCK);

    always_comb begin
        logic [AW-1:0] blk;
        blk = AW'(AW'(r_i0 >> LOG2_BLOCK) * AW'(w_cols)) + AW'(r_i1 >> LOG2_BLOCK);
        w_addr = (blk << (2 * LOG2_BLOCK))
               | AW'({r_i0[LOG2_BLOCK-1:0], r_i1[LOG2_BLOCK-1:0]});
    end

    // saturating updates of the cell and the overflow sum
    always_comb begin
        w_csum = {r_rdata[CELL_BITS-1], r_rdata} + (CELL_BITS+1)'(r_weight);
        if (w_csum[CELL_BITS] != w_csum[CELL_BITS-1]) begin
            w_new_cell = w_csum[CELL_BITS] ? {1'b1, {(CELL_BITS-1){1'b0}}}
                                           : {1'b0, {(CELL_BITS-1){1'b1}}};
        end else begin
            w_new_cell = w_csum[CELL_BITS-1:0];
        end
        if (!(r_accum && r_inr)) begin
            w_new_cell = r_rdata;
        end

        w_osum = {r_ovf[OvfW-1], r_ovf} + (OvfW+1)'(r_weight);
        if (w_osum[OvfW] != w_osum[OvfW-1]) begin
            w_new_ovf = w_osum[OvfW] ? {1'b1, {(OvfW-1){1'b0}}}
                                     : {1'b0, {(OvfW-1){1'b1}}};
        end else begin
            w_new_ovf = w_osum[OvfW-1:0];
        end
        if (!(r_accum && !r_inr)) begin
            w_new_ovf = r_ovf;
        end

        w_value = r_inr ? sat_cell32(w_new_cell) : sat_ovf32(w_new_ovf);
    end

    assign w_addr_ext = (AW+AddrOutW)'(r_addr);

    // memory write port: clearing sweep or write back
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_new_cell;
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (r_state == S_UPD && r_accum && r_inr) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low0  <= '0;
            r_low1  <= '0;
            r_scl0  <= ScaleW'(256);
            r_scl1  <= ScaleW'(256);
            r_bins0 <= BinsW'(64);
            r_bins1 <= BinsW'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AXIS0_LOW:   r_low0  <= i_cfg_wdata;
                CFG_AXIS1_LOW:   r_low1  <= i_cfg_wdata;
                CFG_AXIS0_SCALE: r_scl0  <= i_cfg_wdata;
                CFG_AXIS1_SCALE: r_scl1  <= i_cfg_wdata;
                CFG_AXIS0_BINS:  r_bins0 <= i_cfg_wdata[BinsW-1:0];
                CFG_AXIS1_BINS:  r_bins1 <= i_cfg_wdata[BinsW-1:0];
                default: ;
            endcase
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_accum  <= (i_action == ACT_ACCUM);
            r_weight <= i_sample_weight;
            r_p0     <= w_diff0 * w_sc0;
            r_p1     <= w_diff1 * w_sc1;
        end
        if (r_state == S_BIN) begin
            r_i0  <= XW'(w_b0);
            r_i1  <= XW'(w_b1);
            r_inr <= w_inr0 && w_inr1;
        end
        if (r_state == S_ADDR) begin
            r_addr <= r_inr ? w_addr : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr_addr    <= '0;
            r_clr_reply   <= 1'b0;
            r_ovf         <= '0;
            r_valid       <= 1'b0;
            r_in_range_o  <= 1'b0;
            r_cell_addr_o <= '0;
            r_value_o     <= '0;
        end else begin
            // the sweep after reset ends without a result word
            r_valid <= (r_state == S_UPD)
                    || (r_state == S_CLR && r_clr_addr == AW'(Depth - 1) && r_clr_reply);
            case (r_state)
                S_CLR: begin
                    if (r_clr_addr == AW'(Depth - 1)) begin
                        r_state       <= S_IDLE;
                        r_clr_addr    <= '0;
                        r_ovf         <= '0;
                        r_in_range_o  <= 1'b0;
                        r_cell_addr_o <= '0;
                        r_value_o     <= '0;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_action == ACT_CLEAR) begin
                            r_state     <= S_CLR;
                            r_clr_reply <= 1'b1;
                        end else begin
                            r_state <= S_BIN;
                        end
                    end
                end
                S_BIN:  r_state <= S_ADDR;
                S_ADDR: r_state <= S_RD;
                S_RD:   r_state <= S_UPD;
                S_UPD: begin
                    r_state       <= S_IDLE;
                    r_ovf         <= w_new_ovf;
                    r_in_range_o  <= r_inr;
                    r_cell_addr_o <= w_addr_ext[AddrOutW-1:0];
                    r_value_o     <= w_value;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_in_range       = r_in_range_o;
    assign o_cell_address   = r_cell_addr_o;
    assign o_value          = r_value_o;
    assign o_overflow_total = r_ovf;

    // a result word never overlaps work on the next one
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result words in a row");

    a_out_of_range_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_cell_address == '0))
        else $error("address set for an out of range point");

endmodule

// File: bench/tb_blocked_nd_histogram_accumulator.sv
// self-checking bench for the blocked two-axis weighted histogram
`timescale 1ns / 1ps

module tb_blocked_nd_histogram_accumulator;
    import bnha_pkg::*;

    localparam int MaxBins    = 64;
    localparam int BlkShift   = 2;
    localparam int CellBits   = 32;
    localparam int BlkMask    = (1 << BlkShift) - 1;
    localparam int MaxCols    = (MaxBins + BlkMask) >> BlkShift;
    localparam int StoreDepth = (MaxCols * MaxCols) << (2 * BlkShift);

    localparam longint CellMax = (longint'(1) << (CellBits - 1)) - 1;
    localparam longint CellMin = -CellMax - 1;
    localparam longint OvfMax  = (longint'(1) << (OvfW - 1)) - 1;
    localparam longint OvfMin  = -OvfMax - 1;
    localparam longint ValMax  = (longint'(1) << (ValueW - 1)) - 1;
    localparam longint ValMin  = -ValMax - 1;

    localparam int WatchLimit  = 20000;
    localparam int PileRounds  = 10;
    localparam int RandPhases  = 10;
    localparam int PhaseWords  = 45;
    localparam int DrainCycles = 20;
    localparam int ExpDepth    = 8;

    // the fourth action code behaves as a query
    localparam t_action ActQueryAlt = 2'd3;

    typedef struct {
        logic                       in_range;
        logic [AddrOutW-1:0]        addr;
        logic signed [ValueW-1:0]   value;
        logic signed [OvfW-1:0]     ovf;
    } t_cell_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    t_action                    i_action;
    logic signed [CoordW-1:0]   i_coord_0;
    logic signed [CoordW-1:0]   i_coord_1;
    logic signed [WeightW-1:0]  i_sample_weight;
    logic                       i_cfg_we;
    t_cfg_idx                   i_cfg_idx;
    t_cfg_data                  i_cfg_wdata;
    logic                       o_valid;
    logic                       o_in_range;
    logic [AddrOutW-1:0]        o_cell_address;
    logic signed [ValueW-1:0]   o_value;
    logic signed [OvfW-1:0]     o_overflow_total;

    blocked_nd_histogram_accumulator #(
        .MAX_BINS   (MaxBins),
        .LOG2_BLOCK (BlkShift),
        .CELL_BITS  (CellBits)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_coord_0        (i_coord_0),
        .i_coord_1        (i_coord_1),
        .i_sample_weight  (i_sample_weight),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_in_range       (o_in_range),
        .o_cell_address   (o_cell_address),
        .o_value          (o_value),
        .o_overflow_total (o_overflow_total)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the axis registers and the sums
    logic signed [CoordW-1:0]   low0, low1;
    logic [ScaleW-1:0]          scale0, scale1;
    logic [BinsW-1:0]           bins0, bins1;
    longint                     cell_sum [StoreDepth];
    longint                     ovf_sum;

    // expected results in order, as a small ring
    t_cell_result               awaited_cells [ExpDepth];
    int                         exp_wr = 0;
    int                         exp_rd = 0;
    t_cell_result               want;
    int                         err_count = 0;
    int                         words_sent = 0;
    int                         clears_sent = 0;
    int                         results_seen = 0;
    int                         reg_writes = 0;
    int                         idle_cycles = 0;
    bit                         word_held = 1'b0;

    function automatic longint sat_add(longint acc, longint w, longint lo, longint hi);
        if (w > 0 && acc > hi - w) return hi;
        if (w < 0 && acc < lo - w) return lo;
        return acc + w;
    endfunction

    function automatic longint clip_value(longint v);
        if (v > ValMax) return ValMax;
        if (v < ValMin) return ValMin;
        return v;
    endfunction

    // bin on one axis, truncated toward zero; -1 when outside the axis
    function automatic int bin_of(input logic signed [CoordW-1:0] coord,
                                  input logic signed [CoordW-1:0] lo,
                                  input logic [ScaleW-1:0] sc,
                                  input logic [BinsW-1:0] nbins);
        longint diff, prod, b, lim;
        diff = longint'(coord) - longint'(lo);
        prod = diff * longint'(sc);
        if (prod >= 0) b = prod >>> ScaleFrac;
        else b = -((-prod) >>> ScaleFrac);
        lim = (nbins > MaxBins) ? MaxBins : nbins;
        if (b < 0 || b >= lim) return -1;
        return int'(b);
    endfunction

    function automatic t_cell_result bin_and_accumulate(input t_action act,
                                                        input logic signed [CoordW-1:0] c0,
                                                        input logic signed [CoordW-1:0] c1,
                                                        input logic signed [WeightW-1:0] w);
        t_cell_result r;
        int           i0, i1, cols, blk, addr;
        longint       val;
        r = '{default: '0};
        if (act == ACT_CLEAR) begin
            foreach (cell_sum[k]) cell_sum[k] = 0;
            ovf_sum = 0;
            return r;
        end
        i0 = bin_of(c0, low0, scale0, bins0);
        i1 = bin_of(c1, low1, scale1, bins1);
        if (i0 >= 0 && i1 >= 0) begin
            cols = ((bins1 > MaxBins ? MaxBins : int'(bins1)) + BlkMask) >> BlkShift;
            blk  = (i0 >> BlkShift) * cols + (i1 >> BlkShift);
            addr = (blk << (2 * BlkShift)) | ((i0 & BlkMask) << BlkShift) | (i1 & BlkMask);
            if (act == ACT_ACCUM)
                cell_sum[addr] = sat_add(cell_sum[addr], longint'(w), CellMin, CellMax);
            r.in_range = 1'b1;
            r.addr     = addr[AddrOutW-1:0];
            val        = clip_value(cell_sum[addr]);
        end else begin
            if (act == ACT_ACCUM) ovf_sum = sat_add(ovf_sum, longint'(w), OvfMin, OvfMax);
            val = clip_value(ovf_sum);
        end
        r.value = val[ValueW-1:0];
        r.ovf   = ovf_sum[OvfW-1:0];
        return r;
    endfunction

    function automatic logic signed [CoordW-1:0] pick_low();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return CoordW'($urandom());
        endcase
    endfunction

    function automatic logic [ScaleW-1:0] pick_scale();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hffff;
            3: return 16'd256;
            default: return ScaleW'($urandom_range(1, 1024));
        endcase
    endfunction

    function automatic logic [BinsW-1:0] pick_bins();
        case ($urandom_range(0, 6))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            default: return BinsW'($urandom_range(2, 63));
        endcase
    endfunction

    // mostly aim a little around the bin range of the axis, sometimes anywhere
    function automatic logic signed [CoordW-1:0] aim_coord(input logic signed [CoordW-1:0] lo,
                                                           input logic [ScaleW-1:0] sc);
        int b, diff;
        if ($urandom_range(0, 3) == 0 || sc == 0) return CoordW'($urandom());
        b    = int'($urandom_range(0, MaxBins + 3)) - 2;
        diff = (b * (1 << ScaleFrac) + int'($urandom_range(0, 255))) / int'(sc);
        return lo + diff[CoordW-1:0];
    endfunction

    task automatic stop_words();
        if (word_held) start <= 1'b0;
        word_held = 1'b0;
    endtask

    // start is left high on return so a back-to-back word needs no extra edge
    task automatic send_word(input t_action act,
                             input logic signed [CoordW-1:0] c0,
                             input logic signed [CoordW-1:0] c1,
                             input logic signed [WeightW-1:0] w,
                             input int gap);
        if (gap > 0) begin
            stop_words();
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_action        <= act;
        i_coord_0       <= c0;
        i_coord_1       <= c1;
        i_sample_weight <= w;
        word_held = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        awaited_cells[exp_wr % ExpDepth] = bin_and_accumulate(act, c0, c1, w);
        exp_wr++;
        words_sent++;
        if (act == ACT_CLEAR) clears_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        reg_writes++;
        case (idx)
            CFG_AXIS0_LOW:   low0   = data;
            CFG_AXIS1_LOW:   low1   = data;
            CFG_AXIS0_SCALE: scale0 = data;
            CFG_AXIS1_SCALE: scale1 = data;
            CFG_AXIS0_BINS:  bins0  = data[BinsW-1:0];
            CFG_AXIS1_BINS:  bins1  = data[BinsW-1:0];
            default: ;
        endcase
    endtask

    // only written with nothing in flight
    task automatic set_axes(input logic signed [CoordW-1:0] l0, input logic signed [CoordW-1:0] l1,
                            input logic [ScaleW-1:0] s0, input logic [ScaleW-1:0] s1,
                            input logic [BinsW-1:0] b0, input logic [BinsW-1:0] b1);
        logic [CfgDataW-BinsW-1:0] junk0, junk1;
        junk0 = (CfgDataW-BinsW)'($urandom());
        junk1 = (CfgDataW-BinsW)'($urandom());
        stop_words();
        while ((exp_wr - exp_rd) != 0 || busy !== 1'b0) @(posedge i_clk);
        write_reg(CFG_AXIS0_LOW, l0);
        write_reg(CFG_AXIS1_LOW, l1);
        write_reg(CFG_AXIS0_SCALE, s0);
        write_reg(CFG_AXIS1_SCALE, s1);
        // upper data bits above the bin count are don't-care
        write_reg(CFG_AXIS0_BINS, {junk0, b0});
        write_reg(CFG_AXIS1_BINS, {junk1, b1});
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed_defaults();
        send_word(ACT_ACCUM, 0, 0, 32767, 0);
        send_word(ACT_ACCUM, 0, 0, 32767, 0);
        send_word(ACT_ACCUM, 63, 63, -32768, 0);
        send_word(ACT_ACCUM, 3, 62, 1, 1);
        send_word(ACT_QUERY, 0, 0, 0, 0);
        send_word(ActQueryAlt, 63, 63, 12345, 0);
        send_word(ACT_ACCUM, -1, 5, 100, 2);
        send_word(ACT_ACCUM, 64, 0, -32768, 0);
        send_word(ACT_ACCUM, 32767, -32768, 32767, 0);
        send_word(ACT_QUERY, -32768, 32767, -1, 0);
        send_word(ACT_CLEAR, 7, 7, 7, 0);
        send_word(ACT_QUERY, 0, 0, 0, 3);
        send_word(ACT_QUERY, 70, 70, 0, 0);
    endtask

    task automatic test_axis_extremes();
        // widest scale on one axis, finest on the other, one bin against an over-range count
        set_axes(16'sh8000, 16'sh7fff, 16'hffff, 16'd1, 7'd1, 7'd127);
        send_word(ACT_ACCUM, -32768, 32767, 500, 0);
        send_word(ACT_ACCUM, -32768, 32512, 7, 0);
        send_word(ACT_ACCUM, -32767, 32767, 3, 0);
        send_word(ACT_QUERY, -32768, 32511, 0, 0);
        // scale zero pins axis 0 to bin 0; half scale puts just-below-edge points in bin 0
        set_axes(100, -100, 16'd0, 16'd128, 7'd64, 7'd5);
        send_word(ACT_ACCUM, -32768, -101, 9, 0);
        send_word(ACT_ACCUM, 32767, -91, -9, 1);
        send_word(ACT_QUERY, 0, -90, 0, 0);
        send_word(ACT_ACCUM, 5, -102, 1, 0);
        // no bins on axis 0 sends everything to the overflow sum
        set_axes(0, 0, 16'd256, 16'd256, 7'd0, 7'd64);
        send_word(ACT_ACCUM, 0, 0, 5, 0);
        send_word(ACT_QUERY, 10, 10, 0, 0);
    endtask

    // pile large weights of both signs onto one cell and onto the overflow sum
    task automatic test_weight_pileup();
        set_axes(0, 0, 16'd256, 16'd256, 7'd64, 7'd64);
        send_word(ACT_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < PileRounds; k++) begin
            send_word(ACT_ACCUM, 5, 9, 32767, 0);
            send_word(ACT_ACCUM, -5, 0, -32768, 0);
        end
        send_word(ACT_QUERY, 5, 9, 0, 0);
        send_word(ACT_ACCUM, 5, 9, -32768, 0);
        send_word(ACT_QUERY, -5, 0, 0, 0);
        send_word(ACT_ACCUM, -5, 0, 32767, 0);
    endtask

    task automatic test_random_phases();
        int                         roll;
        t_action                    act;
        logic signed [CoordW-1:0]   c0, c1;
        logic signed [WeightW-1:0]  w;
        for (int p = 0; p < RandPhases; p++) begin
            set_axes(pick_low(), pick_low(), pick_scale(), pick_scale(), pick_bins(), pick_bins());
            for (int n = 0; n < PhaseWords; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 58) act = ACT_ACCUM;
                else if (roll < 83) act = ACT_QUERY;
                else if (roll < 97) act = ActQueryAlt;
                else act = ACT_CLEAR;
                c0 = aim_coord(low0, scale0);
                c1 = aim_coord(low1, scale1);
                w  = WeightW'($urandom());
                send_word(act, c0, c1, w, int'($urandom_range(0, 5)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            results_seen++;
            if ((exp_wr - exp_rd) == 0) begin
                err_count++;
                $display("%0t unexpected word: expected none, got value %0d addr %0d",
                         $time, o_value, o_cell_address);
            end else begin
                want = awaited_cells[exp_rd % ExpDepth];
                exp_rd++;
                if (o_in_range !== want.in_range) begin
                    err_count++;
                    $display("%0t in_range: expected %0d, got %0d",
                             $time, want.in_range, o_in_range);
                end
                if (o_cell_address !== want.addr) begin
                    err_count++;
                    $display("%0t cell_address: expected %0d, got %0d",
                             $time, want.addr, o_cell_address);
                end
                if (o_value !== want.value) begin
                    err_count++;
                    $display("%0t value: expected %0d, got %0d", $time, want.value, o_value);
                end
                if (o_overflow_total !== want.ovf) begin
                    err_count++;
                    $display("%0t overflow_total: expected %0d, got %0d",
                             $time, want.ovf, o_overflow_total);
                end
            end
        end
    end

    // no word in, no word out and no register write for too long
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchLimit) begin
            $display("watchdog: no progress for %0d cycles at %0t", WatchLimit, $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_action        <= ACT_QUERY;
        i_coord_0       <= '0;
        i_coord_1       <= '0;
        i_sample_weight <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_AXIS0_LOW;
        i_cfg_wdata     <= '0;
        low0   = '0;
        low1   = '0;
        scale0 = 16'd256;
        scale1 = 16'd256;
        bins0  = 7'd64;
        bins1  = 7'd64;
        foreach (cell_sum[k]) cell_sum[k] = 0;
        ovf_sum = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_axis_extremes();
        test_weight_pileup();
        test_random_phases();

        stop_words();
        while ((exp_wr - exp_rd) != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("covered %0d words incl. %0d clears and %0d register writes; %0d results checked",
                 words_sent, clears_sent, reg_writes, results_seen);
        $display("axis extremes, bin clamping, zero scale and bin count, weight pile-up");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
